[rtl/core/c_subset_lexer_core_macros.svh]
// Assertion helpers for the checker module.
`ifndef C_SUBSET_LEXER_CORE_MACROS_SVH
`define C_SUBSET_LEXER_CORE_MACROS_SVH

// Checked only while out of reset.
`define CSLX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define CSLX_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cslx_pkg.sv]
package cslx_pkg;

  localparam int TOK_W   = 20;  // width of start and length fields
  localparam int Q_DEPTH = 4;   // result queue entries, power of two

  typedef enum logic [3:0] {
    K_LBRACE   = 4'd0,
    K_RBRACE   = 4'd1,
    K_LPAREN   = 4'd2,
    K_RPAREN   = 4'd3,
    K_SEMI     = 4'd4,
    K_STAR     = 4'd5,
    K_UNKNOWN  = 4'd6,
    K_IDENT    = 4'd7,
    K_KEYWORD  = 4'd8,
    K_OPERATOR = 4'd9,
    K_NUMBER   = 4'd10,
    K_STRING   = 4'd11,
    K_END      = 4'd12
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE,
    M_SLASH,
    M_LINE,
    M_BLOCK,
    M_BLOCK_STAR,
    M_IDENT,
    M_NUMBER,
    M_STRING,
    M_HASH
  } mode_t;

  typedef struct packed {
    kind_t            kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] length;
    logic             last;
  } tok_t;

  // Up to two tokens per accepted byte; tok0 goes out first.
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } step_res_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_LF, CH_TAB, CH_CR};
  endfunction

  // Keyword table: 0 int, 1 float, 2 double, 3 char
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0: n = 3'd3;
      2'd1: n = 3'd5;
      2'd2: n = 3'd6;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [47:0] w;
    logic [7:0]  ch;
    case (k)
      2'd0: w = {"int", 24'h0};
      2'd1: w = {"float", 8'h0};
      2'd2: w = "double";
      default: w = {"char", 16'h0};
    endcase
    case (idx)
      3'd0: ch = w[47:40];
      3'd1: ch = w[39:32];
      3'd2: ch = w[31:24];
      3'd3: ch = w[23:16];
      3'd4: ch = w[15:8];
      3'd5: ch = w[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[rtl/core/cslx_step.sv]
module cslx_step import cslx_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  logic [7:0] c,
  output step_res_t res
);

  localparam logic [OFFSET_BITS-1:0] SAT_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] ONE     = OFFSET_BITS'(1);

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == SAT_MAX) ? v : v + ONE;
  endfunction

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] pstart_r, pstart_nxt;
  logic [OFFSET_BITS-1:0] plen_r, plen_nxt;
  logic [3:0]             alive_r, alive_nxt;

  // classification of the current byte against the open token
  logic                   do_idle;
  logic                   pre_v;
  kind_t                  pre_kind;
  logic [OFFSET_BITS-1:0] pre_len;

  // what the byte does when seen between tokens
  logic                   idle_v;
  kind_t                  idle_kind;
  logic                   idle_pend;
  mode_t                  idle_mode;

  logic                   id_char;
  logic [3:0]             alive_filt;
  logic [3:0]             alive_first;
  logic                   is_kw;
  logic                   ended;

  assign id_char = is_alpha(c) || is_digit(c) || (c == CH_UNDER);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      alive_filt[k]  = alive_r[k] && (plen_r < OFFSET_BITS'(kw_len(2'(k))))
                       && (kw_char(2'(k), plen_r[2:0]) == c);
      alive_first[k] = (kw_char(2'(k), 3'd0) == c);
    end
    is_kw = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (alive_r[k] && (plen_r == OFFSET_BITS'(kw_len(2'(k))))) begin
        is_kw = 1'b1;
      end
    end
  end

  // per-mode decision: close the open token, hand the byte to the idle path
  always_comb begin
    do_idle  = 1'b0;
    pre_v    = 1'b0;
    pre_kind = K_UNKNOWN;
    pre_len  = plen_r;
    case (mode_r)
      M_SLASH: begin
        if (c != CH_SLASH && c != CH_STAR) begin
          pre_v   = 1'b1;
          pre_len = ONE;
          do_idle = 1'b1;
        end
      end
      M_LINE: begin
        do_idle = (c == CH_LF) || (c == CH_NUL);
      end
      M_BLOCK, M_BLOCK_STAR: begin
        do_idle = (c == CH_NUL);
      end
      M_IDENT: begin
        if (!id_char) begin
          pre_v    = 1'b1;
          pre_kind = is_kw ? K_KEYWORD : K_IDENT;
          do_idle  = 1'b1;
        end
      end
      M_NUMBER: begin
        if (!(is_digit(c) || c == CH_DOT || c == CH_LOW_F)) begin
          pre_v    = 1'b1;
          pre_kind = K_NUMBER;
          do_idle  = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          pre_v    = 1'b1;
          pre_kind = K_STRING;
          pre_len  = sat_inc(plen_r);
        end else if (c == CH_NUL) begin
          pre_v    = 1'b1;
          pre_kind = K_STRING;
          do_idle  = 1'b1;
        end
      end
      M_HASH: begin
        if (c == CH_NUL || is_space(c)) begin
          pre_v    = 1'b1;
          pre_kind = K_KEYWORD;
          do_idle  = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase
  end

  // between-token decode
  always_comb begin
    idle_v    = 1'b1;
    idle_kind = K_UNKNOWN;
    idle_pend = 1'b0;
    idle_mode = M_IDLE;
    case (c)
      CH_NUL:    idle_kind = K_END;
      CH_LPAREN: idle_kind = K_LPAREN;
      CH_RPAREN: idle_kind = K_RPAREN;
      CH_LBRACE: idle_kind = K_LBRACE;
      CH_RBRACE: idle_kind = K_RBRACE;
      CH_EQUAL:  idle_kind = K_OPERATOR;
      CH_STAR:   idle_kind = K_STAR;
      CH_SEMI:   idle_kind = K_SEMI;
      default: begin
        if (is_space(c)) begin
          idle_v = 1'b0;
        end else begin
          idle_pend = 1'b1;
          idle_v    = 1'b0;
          if (c == CH_SLASH) begin
            idle_mode = M_SLASH;
          end else if (c == CH_QUOTE) begin
            idle_mode = M_STRING;
          end else if (c == CH_HASH) begin
            idle_mode = M_HASH;
          end else if (is_alpha(c)) begin
            idle_mode = M_IDENT;
          end else if (is_digit(c)) begin
            idle_mode = M_NUMBER;
          end else begin
            idle_v = 1'b1;  // unknown single byte
          end
        end
      end
    endcase
  end

  assign ended = do_idle && (c == CH_NUL);

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    alive_nxt  = alive_r;
    pos_nxt    = ended ? '0 : sat_inc(pos_r);
    if (do_idle) begin
      mode_nxt = idle_mode;
      if (idle_pend) begin
        pstart_nxt = pos_r;
        plen_nxt   = ONE;
      end
      if (idle_mode == M_IDENT) begin
        alive_nxt = alive_first;
      end
    end else begin
      case (mode_r)
        M_SLASH: mode_nxt = (c == CH_SLASH) ? M_LINE : M_BLOCK_STAR;
        M_BLOCK, M_BLOCK_STAR: begin
          if (c == CH_SLASH && mode_r == M_BLOCK_STAR) begin
            mode_nxt = M_IDLE;
          end else begin
            mode_nxt = (c == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
          end
        end
        M_IDENT: begin
          alive_nxt = alive_filt;
          plen_nxt  = sat_inc(plen_r);
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            mode_nxt = M_IDLE;
          end else begin
            plen_nxt = sat_inc(plen_r);
          end
        end
        M_NUMBER, M_HASH: plen_nxt = sat_inc(plen_r);
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // tokens out
  always_comb begin
    tok_t pre_tok;
    tok_t idle_tok;
    logic idle_out;
    pre_tok.kind    = pre_kind;
    pre_tok.start   = TOK_W'(pstart_r);
    pre_tok.length  = TOK_W'(pre_len);
    idle_out        = do_idle && idle_v;
    pre_tok.last    = !idle_out;
    idle_tok.kind   = idle_kind;
    idle_tok.start  = TOK_W'(pos_r);
    idle_tok.length = (idle_kind == K_END) ? '0 : TOK_W'(1);
    idle_tok.last   = 1'b1;
    res.count       = {1'b0, pre_v} + {1'b0, idle_out};
    res.tok0        = pre_v ? pre_tok : idle_tok;
    res.tok1        = idle_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      alive_r  <= '1;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      alive_r  <= alive_nxt;
    end
  end

endmodule

[rtl/core/c_subset_lexer_core.sv]
// Channel | Dir | Ports                        | Word
// --------+-----+------------------------------+----------------------------------------
// in      | in  | in_tvalid/in_tready/in_tdata | [7:0] text_byte (0 ends the text)
// out     | out | out_tvalid/out_tready/       | [3:0] token_kind, [23:4] token_start,
//         |     | out_tdata/out_tlast          | [43:24] token_length; tlast last_of_item
//
// One byte is taken per cycle while in_tready is high; the scanner state updates
// in the accept cycle and the 0..2 tokens it yields land in a 4-entry result
// queue the same edge. The out port drains one word per cycle while out_tready is
// high, so a stream where each byte yields two tokens is bound by that single port.
// in_tready is high while the queue has room for two words; out_tready low
// stalls intake once fewer than two queue entries are free.
// rst_n (synchronous, active low) empties the queue and returns the scanner to
// between-token state at offset zero.
module c_subset_lexer_core import cslx_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] token_kind, [23:4] token_start,
                                  // [43:24] token_length, [47:44] zero
  output logic        out_tlast   // last_of_item
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic       in_acc;
  logic       out_pop;
  step_res_t  res;

  // result queue
  tok_t               q_r [Q_DEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  tok_t               head;

  assign in_tready = (cnt_r <= CNT_W'(Q_DEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;

  cslx_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (in_acc),
    .c    (in_tdata),
    .res  (res)
  );

  assign head       = q_r[rp_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_pop    = out_tvalid && out_tready;
  assign out_tdata  = {4'b0, head.length, head.start, head.kind};
  assign out_tlast  = head.last;

  always_comb begin
    logic [1:0] push_n;
    push_n  = in_acc ? res.count : 2'd0;
    wp_nxt  = wp_r + PTR_W'(push_n);
    rp_nxt  = out_pop ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && res.count != 2'd0) begin
      q_r[wp_r] <= res.tok0;
    end
    if (in_acc && res.count == 2'd2) begin
      q_r[wp_r + PTR_W'(1)] <= res.tok1;
    end
  end

endmodule

[rtl/core/cslx_checker.sv]
`include "c_subset_lexer_core_macros.svh"

module cslx_checker import cslx_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  logic in_word;
  assign in_word = in_tvalid && in_tready && (in_tdata == CH_NUL);

  // a held word must not change under backpressure
  `CSLX_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "out word changed while stalled")

  // queue is empty right after reset
  `CSLX_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "out_tvalid after reset")

  // kind codes stop at end
  `CSLX_ASSERT(a_kind_range, out_tvalid |-> out_tdata[3:0] <= K_END, "token kind out of range")

  // end token closes the byte's results and has no length
  `CSLX_ASSERT(a_end_shape, out_tvalid && out_tdata[3:0] == K_END |-> out_tlast && out_tdata[43:24] == 20'd0, "malformed end token")

  // an end byte always leaves at least its end token queued
  `CSLX_ASSERT(a_end_word, in_word |=> out_tvalid, "no token after end byte")

endmodule

bind c_subset_lexer_core cslx_checker u_cslx_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import cslx_pkg::*;

  localparam int POS_W           = 20;   // offset width of the instance
  localparam int ITEMS_PER_PHASE = 360;
  localparam int NUM_PHASES      = 5;
  localparam int HOLD_CYCLES     = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES    = 12;   // quiet time once all tokens are in
  localparam int NUM_DIR         = 25;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;

  c_subset_lexer_core #(
    .OFFSET_BITS(POS_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog, sized many times over the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Token predictor: mirrors the scanner state one byte at a time.
  // ---------------------------------------------------------------------------
  mode_t            lex_mode;
  logic [TOK_W-1:0] lex_pos;    // offset of the next byte in the text
  logic [TOK_W-1:0] tok_start;  // token being collected
  logic [TOK_W-1:0] tok_len;
  logic [3:0]       kw_live;    // keywords still matching the identifier so far
  bit               text_ended;

  string kw_names [4] = '{"int", "float", "double", "char"};

  tok_t new_tokens[$];       // tokens produced by the byte being predicted
  tok_t expected_tokens[$];  // tokens owed by the block, oldest first

  int mismatches = 0;

  function automatic logic char_is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic char_is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic char_is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic [TOK_W-1:0] sat_inc(logic [TOK_W-1:0] v);
    logic [TOK_W-1:0] top;
    top = TOK_W'((64'd1 << POS_W) - 1);
    return (v >= top) ? top : v + 1'b1;
  endfunction

  // Narrow the live keyword set by character c at index idx.
  function automatic logic [3:0] kw_step(logic [3:0] live, logic [TOK_W-1:0] idx,
                                         logic [7:0] c);
    logic [3:0] r;
    r = 4'h0;
    for (int k = 0; k < 4; k++) begin
      if (live[k] && idx < kw_names[k].len() && kw_names[k][int'(idx)] == c)
        r[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic void add_tok(kind_t k, logic [TOK_W-1:0] s, logic [TOK_W-1:0] l);
    tok_t t;
    t.kind   = k;
    t.start  = s;
    t.length = l;
    t.last   = 1'b0;
    if (new_tokens.size() < 2)
      new_tokens.insert(new_tokens.size(), t);
  endfunction

  function automatic void flush_ident();
    kind_t k;
    k = K_IDENT;
    for (int i = 0; i < 4; i++) begin
      if (kw_live[i] && tok_len == kw_names[i].len())
        k = K_KEYWORD;
    end
    add_tok(k, tok_start, tok_len);
  endfunction

  // Byte seen between tokens.
  function automatic void open_token(logic [7:0] c, logic [TOK_W-1:0] pos);
    lex_mode = M_IDLE;
    if (c == CH_NUL) begin
      text_ended = 1'b1;
      add_tok(K_END, pos, '0);
      return;
    end
    if (char_is_blank(c))
      return;
    case (c)
      CH_LPAREN: begin add_tok(K_LPAREN, pos, TOK_W'(1)); return; end
      CH_RPAREN: begin add_tok(K_RPAREN, pos, TOK_W'(1)); return; end
      CH_LBRACE: begin add_tok(K_LBRACE, pos, TOK_W'(1)); return; end
      CH_RBRACE: begin add_tok(K_RBRACE, pos, TOK_W'(1)); return; end
      CH_EQUAL:  begin add_tok(K_OPERATOR, pos, TOK_W'(1)); return; end
      CH_STAR:   begin add_tok(K_STAR, pos, TOK_W'(1)); return; end
      CH_SEMI:   begin add_tok(K_SEMI, pos, TOK_W'(1)); return; end
      default: ;
    endcase
    tok_start = pos;
    tok_len   = TOK_W'(1);
    if (c == CH_SLASH) begin
      lex_mode = M_SLASH;
    end else if (c == CH_QUOTE) begin
      lex_mode = M_STRING;
    end else if (c == CH_HASH) begin
      lex_mode = M_HASH;
    end else if (char_is_letter(c)) begin
      lex_mode = M_IDENT;
      kw_live  = kw_step(4'hF, '0, c);
    end else if (char_is_digit(c)) begin
      lex_mode = M_NUMBER;
    end else begin
      add_tok(K_UNKNOWN, pos, TOK_W'(1));
    end
  endfunction

  // Fill new_tokens with what byte c yields, last flag on the final one.
  function automatic void predict_tokens(logic [7:0] c);
    logic [TOK_W-1:0] pos;
    pos = lex_pos;
    new_tokens.delete();
    text_ended = 1'b0;
    case (lex_mode)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          lex_mode = M_LINE;
        end else if (c == CH_STAR) begin
          lex_mode = M_BLOCK_STAR;  // opening star may close the comment
        end else begin
          add_tok(K_UNKNOWN, tok_start, TOK_W'(1));
          open_token(c, pos);
        end
      end
      M_LINE: begin
        if (c == CH_LF || c == CH_NUL)
          open_token(c, pos);
      end
      M_BLOCK, M_BLOCK_STAR: begin
        if (c == CH_NUL)
          open_token(c, pos);
        else if (c == CH_SLASH && lex_mode == M_BLOCK_STAR)
          lex_mode = M_IDLE;
        else
          lex_mode = (c == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
      end
      M_IDENT: begin
        if (char_is_letter(c) || char_is_digit(c) || c == CH_UNDER) begin
          kw_live = kw_step(kw_live, tok_len, c);
          tok_len = sat_inc(tok_len);
        end else begin
          flush_ident();
          open_token(c, pos);
        end
      end
      M_NUMBER: begin
        if (char_is_digit(c) || c == CH_DOT || c == CH_LOW_F) begin
          tok_len = sat_inc(tok_len);
        end else begin
          add_tok(K_NUMBER, tok_start, tok_len);
          open_token(c, pos);
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          add_tok(K_STRING, tok_start, sat_inc(tok_len));
          lex_mode = M_IDLE;
        end else if (c == CH_NUL) begin
          // unterminated: emit what there is, then the end token
          add_tok(K_STRING, tok_start, tok_len);
          open_token(c, pos);
        end else begin
          tok_len = sat_inc(tok_len);
        end
      end
      M_HASH: begin
        if (c == CH_NUL || char_is_blank(c)) begin
          add_tok(K_KEYWORD, tok_start, tok_len);
          open_token(c, pos);
        end else begin
          tok_len = sat_inc(tok_len);
        end
      end
      default: open_token(c, pos);
    endcase
    if (new_tokens.size() > 0)
      new_tokens[new_tokens.size()-1].last = 1'b1;
    lex_pos = text_ended ? '0 : sat_inc(lex_pos);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Simple rows carry the token by hand; the rest use the
  // predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] ch;
    logic       fixed;
    tok_t       tok;
  } dir_row_t;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{CH_NUL,    1'b1, '{K_END,      20'd0, 20'd0, 1'b1}},  // end right after reset
    '{CH_LPAREN, 1'b1, '{K_LPAREN,   20'd0, 20'd1, 1'b1}},
    '{CH_RPAREN, 1'b1, '{K_RPAREN,   20'd1, 20'd1, 1'b1}},
    '{CH_LBRACE, 1'b1, '{K_LBRACE,   20'd2, 20'd1, 1'b1}},
    '{CH_RBRACE, 1'b1, '{K_RBRACE,   20'd3, 20'd1, 1'b1}},
    '{CH_SEMI,   1'b1, '{K_SEMI,     20'd4, 20'd1, 1'b1}},
    '{CH_EQUAL,  1'b1, '{K_OPERATOR, 20'd5, 20'd1, 1'b1}},
    '{CH_STAR,   1'b1, '{K_STAR,     20'd6, 20'd1, 1'b1}},
    '{8'hFF,     1'b1, '{K_UNKNOWN,  20'd7, 20'd1, 1'b1}},  // top byte value
    '{CH_UNDER,  1'b1, '{K_UNKNOWN,  20'd8, 20'd1, 1'b1}},  // underscore can't lead
    '{"i",       1'b0, '0},                                 // "int " keyword
    '{"n",       1'b0, '0},
    '{"t",       1'b0, '0},
    '{CH_SPACE,  1'b0, '0},
    '{CH_SLASH,  1'b0, '0},                                 // slash-star-slash
    '{CH_STAR,   1'b0, '0},
    '{CH_SLASH,  1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},                                 // open string at end
    '{"a",       1'b0, '0},
    '{CH_NUL,    1'b0, '0},
    '{"7",       1'b0, '0},                                 // number, slash at end
    '{CH_SLASH,  1'b0, '0},
    '{CH_NUL,    1'b0, '0},
    '{CH_HASH,   1'b0, '0},                                 // hash token at end
    '{CH_NUL,    1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int   sender_idle_pct = 0;
  int   recv_stall_pct  = 0;
  bit   recv_hold       = 1'b0;
  event start_hold;

  logic [7:0] src_bytes[$];  // fragment of source text waiting to go out

  function automatic void add_src(logic [7:0] b);
    src_bytes.insert(src_bytes.size(), b);
  endfunction

  // Offer one byte; on acceptance book the tokens it owes.
  task automatic drive_byte(input logic [7:0] b, input logic fixed, input tok_t fixed_tok);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_tokens(b);  // keeps predictor state in step either way
    if (fixed)
      expected_tokens.insert(expected_tokens.size(), fixed_tok);
    else
      foreach (new_tokens[i]) expected_tokens.insert(expected_tokens.size(), new_tokens[i]);
    @(negedge clk);
  endtask

  // Stop sending until every owed token is back, plus pipeline slack.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(9);
    if (r < 6) return rand_letter();
    if (r < 9) return 8'("0" + $urandom_range(9));
    return CH_UNDER;
  endfunction

  // Mostly well-formed C fragments with random content, some noise and
  // broken pieces.
  function automatic void build_fragment();
    int         sel;
    int         n;
    logic [7:0] c;
    string      kw;
    sel = $urandom_range(99);
    if (sel < 20) begin
      add_src(rand_letter());
      n = $urandom_range(7);
      repeat (n) add_src(rand_word_char());
    end else if (sel < 30) begin
      kw = kw_names[$urandom_range(3)];
      n  = kw.len();
      if ($urandom_range(99) < 15) n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) add_src(kw[i]);
      if ($urandom_range(99) < 25) add_src(rand_word_char());
    end else if (sel < 40) begin
      add_src(8'("0" + $urandom_range(9)));
      n = $urandom_range(5);
      repeat (n) begin
        case ($urandom_range(3))
          0: add_src(CH_DOT);
          1: add_src(CH_LOW_F);
          default: add_src(8'("0" + $urandom_range(9)));
        endcase
      end
    end else if (sel < 50) begin
      case ($urandom_range(6))
        0: add_src(CH_LPAREN);
        1: add_src(CH_RPAREN);
        2: add_src(CH_LBRACE);
        3: add_src(CH_RBRACE);
        4: add_src(CH_SEMI);
        5: add_src(CH_EQUAL);
        default: add_src(CH_STAR);
      endcase
    end else if (sel < 58) begin
      add_src(CH_QUOTE);
      n = $urandom_range(6);
      repeat (n) begin
        do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE);
        add_src(c);
      end
      add_src(($urandom_range(99) < 15) ? CH_NUL : CH_QUOTE);
    end else if (sel < 64) begin
      add_src(CH_SLASH);
      add_src(CH_SLASH);
      n = $urandom_range(6);
      repeat (n) add_src(8'($urandom_range(32, 126)));
      add_src(($urandom_range(99) < 20) ? CH_NUL : CH_LF);
    end else if (sel < 72) begin
      add_src(CH_SLASH);
      add_src(CH_STAR);
      if ($urandom_range(99) < 20) begin
        add_src(CH_SLASH);
      end else begin
        n = $urandom_range(6);
        repeat (n) add_src($urandom_range(2) == 0 ? CH_STAR
                                                  : 8'($urandom_range(32, 126)));
        n = $urandom_range(9);
        if (n < 8) begin
          add_src(CH_STAR);
          add_src(CH_SLASH);
        end else if (n == 8) begin
          add_src(CH_NUL);  // comment still open at end of text
        end
      end
    end else if (sel < 77) begin
      add_src(CH_HASH);
      n = $urandom_range(4);
      repeat (n) add_src(8'($urandom_range(33, 126)));
      case ($urandom_range(3))
        0: add_src(CH_NUL);
        1: add_src(CH_TAB);
        default: add_src(CH_SPACE);
      endcase
    end else if (sel < 80) begin
      add_src(CH_SLASH);
    end else if (sel < 92) begin
      case ($urandom_range(3))
        0: add_src(CH_TAB);
        1: add_src(CH_CR);
        2: add_src(CH_LF);
        default: add_src(CH_SPACE);
      endcase
    end else if (sel < 97) begin
      add_src(8'($urandom_range(255)));
    end else begin
      add_src(CH_NUL);
    end
  endfunction

  // Idle mix per phase: none, sender 70, receiver 70, both 30, then a long
  // receiver hold-off while the sender keeps pushing.
  int idle_mix  [NUM_PHASES] = '{0, 70, 0, 30, 0};
  int stall_mix [NUM_PHASES] = '{0, 0, 70, 30, 0};

  initial begin
    int sent;
    lex_mode  = M_IDLE;
    lex_pos   = '0;
    tok_start = '0;
    tok_len   = '0;
    kw_live   = 4'hF;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    recv_stall_pct = 30;
    foreach (dir_rows[i]) drive_byte(dir_rows[i].ch, dir_rows[i].fixed, dir_rows[i].tok);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sender_idle_pct = idle_mix[ph];
      recv_stall_pct  = stall_mix[ph];
      if (ph == NUM_PHASES - 1) -> start_hold;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        build_fragment();
        while (src_bytes.size() != 0) begin
          drive_byte(src_bytes.pop_front(), 1'b0, '0);
          sent++;
        end
      end
      drain_results();
    end

    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Long hold-off, counted here so the sender keeps offering meanwhile.
  initial begin
    forever begin
      @(start_hold);
      recv_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      recv_hold = 1'b0;
    end
  end

  always @(negedge clk) begin
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result check: each accepted word against the oldest owed token.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token word %h last %b", out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_tdata[3:0] != want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_tdata[3:0]);
          mismatches++;
        end
        if (out_tdata[23:4] != want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, out_tdata[23:4]);
          mismatches++;
        end
        if (out_tdata[43:24] != want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, out_tdata[43:24]);
          mismatches++;
        end
        if (out_tlast != want.last) begin
          $error("last_of_item: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

endmodule
